FILE: rtl/eqf_pkg.sv
package eqf_pkg;

  // sample history taps (x1..x12)
  localparam int X_DEPTH    = 12;
  localparam int X_TAP_MID  = 6;

  // low pass history ring, taps lp16 and lp32, lp17 is lp16 one beat later
  localparam int LP_DEPTH   = 32;
  localparam int LP_AW      = $clog2(LP_DEPTH);
  localparam int LP_CW      = $clog2(LP_DEPTH + 1);
  localparam int LP_TAP_A   = 16;
  localparam int LP_SHIFT   = 5;

  // high pass history, current value plus hp1..hp4
  localparam int HP_DEPTH   = 4;
  localparam int DERIV_SHIFT = 3;

  // moving window
  localparam int WINDOW     = 30;
  localparam int WIN_AW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int WIN_CW     = $clog2(WINDOW + 1);

  // mean by reciprocal: q0 = (m * floor(2^31 / WINDOW)) >> 31, then one correction
  localparam logic [31:0] MEAN_RECIP = 32'((64'd1 << 31) / WINDOW);
  localparam int REM_W      = (WINDOW > 1) ? $clog2(2 * WINDOW) : 1;

  // output queue and in-flight accounting
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

  // register stages from input beat to a finished result
  localparam int PIPE_LAT   = 12;

  typedef struct packed {
    logic        vld;
    logic [31:0] hp;
    logic [31:0] deriv;
  } eqf_deriv_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] hp;
    logic [31:0] sum;
  } eqf_sum_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] hp;
    logic [31:0] mean;
  } eqf_res_t;

  // signed division by 2^k, truncating toward zero
  function automatic logic [31:0] sdiv_pow2(input logic [31:0] v, input int unsigned k);
    logic [31:0] bias;
    logic [31:0] s;
    bias = v[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    s = v + bias;
    return 32'($signed(s) >>> k);
  endfunction

endpackage

FILE: rtl/eqf_filter.sv
module eqf_filter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc_i,
  input  logic signed [15:0]    sample_i,
  output eqf_pkg::eqf_deriv_t   deriv_o
);

  // sample history
  logic [15:0] x_hist_r [eqf_pkg::X_DEPTH];

  // stage valids
  logic fv1_r, fv2_r, fv3_r, fv4_r, fv5_r;

  // stage payloads
  logic [31:0] fir_r;
  logic [31:0] lp_s2_r, pre_r;
  logic [31:0] q_r;
  logic [31:0] hp_s4_r;
  logic [31:0] deriv_r, hp_s5_r;

  // recursive state
  logic [31:0] lp1_r, lp2_r, lp17_r;
  logic [31:0] hp_hist_r [eqf_pkg::HP_DEPTH + 1];

  // low pass ring memory
  logic [31:0] lp_mem [eqf_pkg::LP_DEPTH];
  logic [eqf_pkg::LP_AW-1:0] wptr_r, ptr_nxt, ra16;
  logic [eqf_pkg::LP_CW-1:0] fill_r;
  logic [31:0] rd16_r, rd32_r;

  logic [31:0] xs, x6s, x12s, sumx, fir;
  logic [31:0] lp, lp16m, lp32m, pre, q, hp, deriv;

  // fir part of the low pass, straight from the sample history
  always_comb begin
    xs   = {{16{sample_i[15]}}, sample_i};
    x6s  = {{16{x_hist_r[eqf_pkg::X_TAP_MID-1][15]}}, x_hist_r[eqf_pkg::X_TAP_MID-1]};
    x12s = {{16{x_hist_r[eqf_pkg::X_DEPTH-1][15]}}, x_hist_r[eqf_pkg::X_DEPTH-1]};
    sumx = xs - (x6s << 1) + x12s;
    fir  = eqf_pkg::sdiv_pow2(sumx, eqf_pkg::LP_SHIFT);
  end

  // low pass recursion and the delayed low pass terms of the high pass
  always_comb begin
    lp    = (lp1_r << 1) - lp2_r + fir_r;
    lp16m = (fill_r >= eqf_pkg::LP_CW'(eqf_pkg::LP_TAP_A)) ? rd16_r : 32'd0;
    lp32m = (fill_r >= eqf_pkg::LP_CW'(eqf_pkg::LP_DEPTH)) ? rd32_r : 32'd0;
    pre   = lp16m - lp17_r + eqf_pkg::sdiv_pow2(lp32m, eqf_pkg::LP_SHIFT);
    q     = pre_r - eqf_pkg::sdiv_pow2(lp_s2_r, eqf_pkg::LP_SHIFT);
    hp    = hp_hist_r[0] + q_r;
    deriv = (hp_hist_r[0] << 1) + hp_hist_r[1] - hp_hist_r[3] - (hp_hist_r[4] << 1);
  end

  // prefetch address follows the pointer that the next low pass beat will use
  always_comb begin
    if (!rst_n) begin
      ptr_nxt = '0;
    end else if (fv1_r) begin
      ptr_nxt = wptr_r + eqf_pkg::LP_AW'(1);
    end else begin
      ptr_nxt = wptr_r;
    end
    ra16 = ptr_nxt - eqf_pkg::LP_AW'(eqf_pkg::LP_TAP_A);
  end

  // ring write and two registered reads, never the same entry in one cycle
  always_ff @(posedge clk) begin
    if (fv1_r) begin
      lp_mem[wptr_r] <= lp;
    end
    rd16_r <= lp_mem[ra16];
    rd32_r <= lp_mem[ptr_nxt];
  end

  // control and history state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv1_r  <= 1'b0;
      fv2_r  <= 1'b0;
      fv3_r  <= 1'b0;
      fv4_r  <= 1'b0;
      fv5_r  <= 1'b0;
      wptr_r <= '0;
      fill_r <= '0;
      lp1_r  <= '0;
      lp2_r  <= '0;
      lp17_r <= '0;
      for (int i = 0; i < eqf_pkg::X_DEPTH; i++) x_hist_r[i] <= '0;
      for (int i = 0; i <= eqf_pkg::HP_DEPTH; i++) hp_hist_r[i] <= '0;
    end else begin
      fv1_r <= acc_i;
      fv2_r <= fv1_r;
      fv3_r <= fv2_r;
      fv4_r <= fv3_r;
      fv5_r <= fv4_r;
      if (acc_i) begin
        x_hist_r[0] <= sample_i;
        for (int i = 1; i < eqf_pkg::X_DEPTH; i++) x_hist_r[i] <= x_hist_r[i-1];
      end
      if (fv1_r) begin
        wptr_r <= wptr_r + eqf_pkg::LP_AW'(1);
        if (fill_r != eqf_pkg::LP_CW'(eqf_pkg::LP_DEPTH)) begin
          fill_r <= fill_r + eqf_pkg::LP_CW'(1);
        end
        lp1_r  <= lp;
        lp2_r  <= lp1_r;
        lp17_r <= lp16m;
      end
      if (fv3_r) begin
        hp_hist_r[0] <= hp;
        for (int i = 1; i <= eqf_pkg::HP_DEPTH; i++) hp_hist_r[i] <= hp_hist_r[i-1];
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    fir_r   <= fir;
    lp_s2_r <= lp;
    pre_r   <= pre;
    q_r     <= q;
    hp_s4_r <= hp;
    deriv_r <= deriv;
    hp_s5_r <= hp_s4_r;
  end

  assign deriv_o.vld   = fv5_r;
  assign deriv_o.hp    = hp_s5_r;
  assign deriv_o.deriv = deriv_r;

endmodule

FILE: rtl/eqf_window.sv
module eqf_window (
  input  logic                clk,
  input  logic                rst_n,
  input  eqf_pkg::eqf_deriv_t deriv_i,
  output eqf_pkg::eqf_sum_t   sum_o
);

  logic wv1_r, wv2_r, wv3_r;
  logic [31:0] d_r, hp1_r;
  logic [31:0] sq_r, hp2_r;
  logic [31:0] hp3_r;

  // square ring memory and running sum
  logic [31:0] sq_mem [eqf_pkg::WINDOW];
  logic [eqf_pkg::WIN_AW-1:0] pos_r, pos_inc, pos_nxt;
  logic [eqf_pkg::WIN_CW-1:0] fill_r;
  logic [31:0] rd_r, old_sq, sum_r;
  logic [63:0] sq_full;

  // square, keeping the low word
  assign sq_full = d_r * d_r;

  // next ring slot, wrapping at the window length
  always_comb begin
    pos_inc = (pos_r == eqf_pkg::WIN_AW'(eqf_pkg::WINDOW - 1)) ?
              '0 : pos_r + eqf_pkg::WIN_AW'(1);
    if (!rst_n) begin
      pos_nxt = '0;
    end else if (wv2_r) begin
      pos_nxt = pos_inc;
    end else begin
      pos_nxt = pos_r;
    end
    old_sq = (fill_r == eqf_pkg::WIN_CW'(eqf_pkg::WINDOW)) ? rd_r : 32'd0;
  end

  // write the new square, prefetch the slot for the next beat with forwarding
  always_ff @(posedge clk) begin
    if (wv2_r) begin
      sq_mem[pos_r] <= sq_r;
    end
    if (wv2_r && (pos_nxt == pos_r)) begin
      rd_r <= sq_r;
    end else begin
      rd_r <= sq_mem[pos_nxt];
    end
  end

  // control and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv1_r  <= 1'b0;
      wv2_r  <= 1'b0;
      wv3_r  <= 1'b0;
      pos_r  <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else begin
      wv1_r <= deriv_i.vld;
      wv2_r <= wv1_r;
      wv3_r <= wv2_r;
      if (wv2_r) begin
        pos_r <= pos_inc;
        sum_r <= sum_r - old_sq + sq_r;
        if (fill_r != eqf_pkg::WIN_CW'(eqf_pkg::WINDOW)) begin
          fill_r <= fill_r + eqf_pkg::WIN_CW'(1);
        end
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    d_r   <= eqf_pkg::sdiv_pow2(deriv_i.deriv, eqf_pkg::DERIV_SHIFT);
    hp1_r <= deriv_i.hp;
    sq_r  <= sq_full[31:0];
    hp2_r <= hp1_r;
    hp3_r <= hp2_r;
  end

  assign sum_o.vld = wv3_r;
  assign sum_o.hp  = hp3_r;
  assign sum_o.sum = sum_r;

endmodule

FILE: rtl/eqf_mean_div.sv
module eqf_mean_div (
  input  logic              clk,
  input  logic              rst_n,
  input  eqf_pkg::eqf_sum_t sum_i,
  output eqf_pkg::eqf_res_t res_o
);

  logic dv1_r, dv2_r, dv3_r, dv4_r;
  logic        neg1_r, neg2_r, neg3_r;
  logic [31:0] mag1_r, mag2_r;
  logic [63:0] prod_r;
  logic [31:0] q0_r;
  logic [eqf_pkg::REM_W-1:0] rem_r;
  logic [31:0] res_r;
  logic [31:0] hp1_r, hp2_r, hp3_r, hp4_r;

  logic [31:0] q0, qw, rem;
  logic        carry;

  // estimate from the reciprocal, then the remainder for the correction
  always_comb begin
    q0  = prod_r[62:31];
    qw  = q0 * 32'(eqf_pkg::WINDOW);
    rem = mag2_r - qw;
  end

  assign carry = (rem_r >= eqf_pkg::REM_W'(eqf_pkg::WINDOW));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv1_r <= 1'b0;
      dv2_r <= 1'b0;
      dv3_r <= 1'b0;
      dv4_r <= 1'b0;
    end else begin
      dv1_r <= sum_i.vld;
      dv2_r <= dv1_r;
      dv3_r <= dv2_r;
      dv4_r <= dv3_r;
    end
  end

  // magnitude, product, correction, signed result
  always_ff @(posedge clk) begin
    neg1_r <= sum_i.sum[31];
    mag1_r <= sum_i.sum[31] ? (32'd0 - sum_i.sum) : sum_i.sum;
    hp1_r  <= sum_i.hp;
    prod_r <= mag1_r * eqf_pkg::MEAN_RECIP;
    mag2_r <= mag1_r;
    neg2_r <= neg1_r;
    hp2_r  <= hp1_r;
    q0_r   <= q0;
    rem_r  <= rem[eqf_pkg::REM_W-1:0];
    neg3_r <= neg2_r;
    hp3_r  <= hp2_r;
    // negate as ~q0 + 1 - carry to keep one adder
    res_r  <= neg3_r ? (~q0_r + {31'd0, ~carry}) : (q0_r + {31'd0, carry});
    hp4_r  <= hp3_r;
  end

  assign res_o.vld  = dv4_r;
  assign res_o.hp   = hp4_r;
  assign res_o.mean = res_r;

endmodule

FILE: rtl/eqf_out_fifo.sv
module eqf_out_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  eqf_pkg::eqf_res_t           res_i,
  input  logic                        stall_i,
  output logic                        valid_o,
  output logic signed [31:0]          integrated_o,
  output logic signed [31:0]          bandpassed_o,
  output logic [eqf_pkg::OCC_W-1:0]   cnt_o
);

  logic [63:0] q_mem [eqf_pkg::FIFO_DEPTH];
  logic [eqf_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [eqf_pkg::OCC_W-1:0]   cnt_r;
  logic wr_en, rd_en;

  assign wr_en = res_i.vld;
  assign rd_en = (cnt_r != '0) && !stall_i;

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_mem[wr_ptr_r] <= {res_i.mean, res_i.hp};
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + eqf_pkg::FIFO_AW'(1);
      if (rd_en) rd_ptr_r <= rd_ptr_r + eqf_pkg::FIFO_AW'(1);
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + eqf_pkg::OCC_W'(1);
        2'b01:   cnt_r <= cnt_r - eqf_pkg::OCC_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign valid_o      = (cnt_r != '0);
  assign integrated_o = q_mem[rd_ptr_r][63:32];
  assign bandpassed_o = q_mem[rd_ptr_r][31:0];
  assign cnt_o        = cnt_r;

endmodule

FILE: rtl/ecg_qrs_filter_chain.sv
// QRS enhancement chain: low pass, high pass, derivative, square and
// moving window mean over one signed 16-bit ECG sample per beat.
// Input channel in_valid / in_stall / in_sample; result channel out_valid /
// out_stall / out_integrated / out_bandpassed, one result beat per sample, in order.
// Throughput: one sample per clock cycle, sustained while in_stall is low. That
// rate is set by the feedback of the low pass and high pass recursions and by the
// two ring memories (low pass history, window squares), each written once a cycle.
// Each accepted sample passes 12 register stages and then the output queue
// before its result is shown on out_valid.
// Reset (rst_n low, synchronous) clears all histories, the running sum, the ring
// pointers and the ring fill counts; unwritten ring entries read as zero through
// the fill counts, so there is no clearing pass and samples are taken right away.
// When the receiver stalls, finished results collect in a 16-entry queue and the
// chain keeps working; in_stall rises only once 16 samples are in flight or waiting.
module ecg_qrs_filter_chain (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_integrated,
  output logic signed [31:0] out_bandpassed
);

  eqf_pkg::eqf_deriv_t deriv;
  eqf_pkg::eqf_sum_t   wsum;
  eqf_pkg::eqf_res_t   res;

  logic [eqf_pkg::OCC_W-1:0] occ_r, fifo_cnt;
  logic in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // samples accepted and not yet delivered, bounded by the queue depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   occ_r <= occ_r + eqf_pkg::OCC_W'(1);
        2'b01:   occ_r <= occ_r - eqf_pkg::OCC_W'(1);
        default: occ_r <= occ_r;
      endcase
    end
  end

  assign in_stall = (occ_r == eqf_pkg::OCC_W'(eqf_pkg::FIFO_DEPTH));

  eqf_filter u_filter (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc_i    (in_acc),
    .sample_i (in_sample),
    .deriv_o  (deriv)
  );

  eqf_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .deriv_i (deriv),
    .sum_o   (wsum)
  );

  eqf_mean_div u_mean_div (
    .clk   (clk),
    .rst_n (rst_n),
    .sum_i (wsum),
    .res_o (res)
  );

  eqf_out_fifo u_out_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_i        (res),
    .stall_i      (out_stall),
    .valid_o      (out_valid),
    .integrated_o (out_integrated),
    .bandpassed_o (out_bandpassed),
    .cnt_o        (fifo_cnt)
  );

  // in-flight count never passes the queue depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= eqf_pkg::OCC_W'(eqf_pkg::FIFO_DEPTH))
    else $error("in-flight count above queue depth");

  // every accepted sample comes out of the divider after the PIPE_LAT register stages
  a_pipe_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##(eqf_pkg::PIPE_LAT) res.vld)
    else $error("result missing at expected pipeline depth");

  // a finished result always finds room in the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |-> (fifo_cnt != eqf_pkg::OCC_W'(eqf_pkg::FIFO_DEPTH)))
    else $error("result written into a full queue");

  // queued results are always counted as in flight
  a_queue_counted: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt <= occ_r)
    else $error("queue holds more than the in-flight count");

endmodule
